// File: rtl/core/ssrc_pkg.sv
package ssrc_pkg;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int RPM_W      = 17;
  localparam int ACCEL_W    = 15;
  localparam int INTERVAL_W = 16;
  localparam int PERIOD_W   = 19;
  localparam int SPEED_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Serial divider: dividend width and kept quotient bits
  localparam int NUM_W = 37;
  localparam int QUO_W = 20;
  localparam int CNT_W = 6;

  // Half period dividend: 500000 us * 256 * 60
  localparam logic [NUM_W-1:0] HP_DIVIDEND = 37'd7680000000;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 19'd500000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 19'd2;
  localparam logic [RPM_W-1:0]    TARGET_MIN   = 17'd12800;
  localparam logic [RPM_W-1:0]    TARGET_MAX   = 17'd102400;
  localparam logic [RPM_W-1:0]    RETUNE_DELTA = 17'd128;

  // Reset values of the configuration registers and the target
  localparam logic [ACCEL_W-1:0]    ACCEL_RST    = 15'd2000;
  localparam logic [RPM_W-1:0]      MIN_RAMP_RST = 17'd7680;
  localparam logic [RPM_W-1:0]      LIMIT_RST    = 17'd38400;
  localparam logic [RPM_W-1:0]      INCR_RST     = 17'd12800;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd3000;
  localparam logic [RPM_W-1:0]      GOAL_RST     = 17'd38400;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_START_CONT = 3'd1,
    CMD_START_AUTO = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_SET_TARGET = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL    = 3'd0,
    REG_MIN_RAMP = 3'd1,
    REG_LIMIT    = 3'd2,
    REG_INCR     = 3'd3,
    REG_INTERVAL = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DELTA = 10'b0000000010,
    ST_RAMP  = 10'b0000000100,
    ST_STEP  = 10'b0000001000,
    ST_FLOOR = 10'b0000010000,
    ST_CHECK = 10'b0000100000,
    ST_MULT  = 10'b0001000000,
    ST_DIV   = 10'b0010000000,
    ST_AUTO  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  // Clamp a requested target to the allowed speed window
  function automatic logic [RPM_W-1:0] clamp_target(input logic [RPM_W:0] v);
    logic [RPM_W-1:0] r;
    if (v < {1'b0, TARGET_MIN}) begin
      r = TARGET_MIN;
    end else if (v > {1'b0, TARGET_MAX}) begin
      r = TARGET_MAX;
    end else begin
      r = v[RPM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/stepper_speed_ramp_controller.sv
// Stepper speed ramp controller. Each command transaction (tick, start continuous, start auto
// ramp, stop, set target) yields exactly one result transaction holding the state after the
// command. The result is presented in the same cycle in which in_ready rises for the next
// command. Stop, set target, an idle tick and unused codes go straight to the result. A start
// skips the division when the floor speed gives less than one step per second, and a running
// tick skips the speed step when the speed already sits on the target. When a tick retunes, the
// new half period comes from a bit-serial restoring divider that retires one quotient bit per
// cycle over a 37-bit dividend. The first running tick after reset or after a write of the
// acceleration register also uses the same divider to derive the per-tick speed step.
// A new command is taken while the previous result still waits on out_ready.
module stepper_speed_ramp_controller #(
  parameter int STEPS_PER_REVOLUTION = 1600
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ssrc_pkg::CMD_W-1:0]         command,
  input  logic [ssrc_pkg::RPM_W-1:0]         rpm_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               running,
  output logic                               auto_active,
  output logic [ssrc_pkg::RPM_W-1:0]         current_speed,
  output logic [ssrc_pkg::RPM_W-1:0]         target_speed,
  output logic                               retune,
  output logic [ssrc_pkg::PERIOD_W-1:0]      half_period_us,
  output logic                               driver_enable_n,
  input  logic                               cfg_write,
  input  logic [ssrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ssrc_pkg::*;

  localparam int SPR_W = $clog2(STEPS_PER_REVOLUTION + 1);
  localparam int DEN_W = RPM_W + SPR_W;
  localparam logic [DEN_W-1:0] DELTA_DEN = DEN_W'(STEPS_PER_REVOLUTION * 1000);
  localparam logic [SPR_W-1:0] SPR = SPR_W'(STEPS_PER_REVOLUTION);
  // Speeds below this give fewer than one step per second
  localparam logic [RPM_W-1:0] R_FLOOR =
    RPM_W'((15360 + STEPS_PER_REVOLUTION - 1) / STEPS_PER_REVOLUTION);

  // Configuration registers
  logic [ACCEL_W-1:0]    acceleration;
  logic [RPM_W-1:0]      floor_rpm;
  logic [RPM_W-1:0]      auto_ramp_limit;
  logic [RPM_W-1:0]      auto_ramp_increment;
  logic [INTERVAL_W-1:0] auto_ramp_interval;

  // Controller state
  state_t state, state_next;
  logic                  run_mode;
  logic                  auto_mode;
  logic [SPEED_W-1:0]    speed_now;
  logic [RPM_W-1:0]      speed_goal;
  logic [RPM_W-1:0]      applied_speed;
  logic                  applied_valid;
  logic [PERIOD_W-1:0]   period_now;
  logic [INTERVAL_W-1:0] interval_count;
  logic                  enable_level;
  logic                  retune_flag;
  logic                  tick_cmd;
  logic [QUO_W-1:0]      delta;
  logic                  delta_dirty;
  logic [SPEED_W-1:0]    gap;
  logic                  dir_up;

  // Serial divider
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] div_cnt;
  logic [DEN_W:0]   rem_sh;
  logic             rem_ge;
  logic             div_last;

  // Combinational helpers
  logic [SPEED_W-1:0]    goal_x;
  logic [SPEED_W-1:0]    floor_x;
  logic [RPM_W-1:0]      cur;
  logic [RPM_W-1:0]      diff;
  logic                  retune_hit;
  logic [INTERVAL_W-1:0] cnt_inc;
  logic [RPM_W:0]        goal_sum;
  logic [20:0]           accel_x60;
  logic                  out_free;
  logic [QUO_W-1:0]      hp_quo;
  state_t                after_apply;

  assign goal_x    = {1'b0, speed_goal, 8'b0};
  assign floor_x   = {1'b0, floor_rpm, 8'b0};
  assign cur       = speed_now[RPM_W+7:8];
  assign diff      = (cur > applied_speed) ? (cur - applied_speed) : (applied_speed - cur);
  assign retune_hit = !applied_valid || (diff >= RETUNE_DELTA);
  assign cnt_inc   = (interval_count == '1) ? interval_count : interval_count + 1'b1;
  assign goal_sum  = {1'b0, speed_goal} + {1'b0, auto_ramp_increment};
  assign accel_x60 = {acceleration, 6'b0} - {4'b0, acceleration, 2'b0};
  assign out_free  = !out_valid || out_ready;
  assign hp_quo    = {quo[QUO_W-2:0], rem_ge};
  assign after_apply = tick_cmd ? ST_AUTO : ST_DONE;

  assign rem_sh   = {rem, num[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign div_last = (div_cnt == CNT_W'(NUM_W - 1));

  assign in_ready = (state == ST_IDLE);

  // Pick the next sequencer state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(command))
            CMD_TICK: begin
              if (!run_mode) begin
                state_next = ST_DONE;
              end else if (delta_dirty) begin
                state_next = ST_DELTA;
              end else begin
                state_next = ST_RAMP;
              end
            end
            CMD_START_CONT, CMD_START_AUTO: state_next = ST_MULT;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DELTA: state_next = div_last ? ST_RAMP : ST_DELTA;
      ST_RAMP:  state_next = (speed_now == goal_x) ? ST_AUTO : ST_STEP;
      ST_STEP:  state_next = ST_FLOOR;
      ST_FLOOR: state_next = ST_CHECK;
      ST_CHECK: state_next = retune_hit ? ST_MULT : ST_AUTO;
      ST_MULT:  state_next = (applied_speed < R_FLOOR) ? after_apply : ST_DIV;
      ST_DIV:   state_next = div_last ? after_apply : ST_DIV;
      ST_AUTO:  state_next = ST_DONE;
      ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      acceleration        <= ACCEL_RST;
      floor_rpm           <= MIN_RAMP_RST;
      auto_ramp_limit     <= LIMIT_RST;
      auto_ramp_increment <= INCR_RST;
      auto_ramp_interval  <= INTERVAL_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_ACCEL:    acceleration        <= cfg_data[ACCEL_W-1:0];
        REG_MIN_RAMP: floor_rpm           <= cfg_data[RPM_W-1:0];
        REG_LIMIT:    auto_ramp_limit     <= cfg_data[RPM_W-1:0];
        REG_INCR:     auto_ramp_increment <= cfg_data[RPM_W-1:0];
        REG_INTERVAL: auto_ramp_interval  <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Load the serial divider, then advance it one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      num     <= {accel_x60, 16'b0};
      den     <= DELTA_DEN;
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == ST_MULT) begin
      num     <= HP_DIVIDEND;
      den     <= DEN_W'(applied_speed) * DEN_W'(SPR);
      rem     <= '0;
      div_cnt <= '0;
    end else begin
      num     <= {num[NUM_W-2:0], 1'b0};
      rem     <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      quo     <= hp_quo;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Step the controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode       <= 1'b0;
      auto_mode      <= 1'b0;
      speed_now      <= '0;
      speed_goal     <= GOAL_RST;
      applied_speed  <= '0;
      applied_valid  <= 1'b0;
      period_now     <= '0;
      interval_count <= '0;
      enable_level   <= 1'b1;
      retune_flag    <= 1'b0;
      tick_cmd       <= 1'b0;
      delta          <= '0;
      delta_dirty    <= 1'b1;
    end else begin
      // A new acceleration needs a fresh speed step
      if (cfg_write && reg_idx_t'(cfg_index) == REG_ACCEL) begin
        delta_dirty <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            retune_flag <= 1'b0;
            tick_cmd    <= (cmd_t'(command) == CMD_TICK);
            case (cmd_t'(command))
              CMD_START_CONT, CMD_START_AUTO: begin
                if (cmd_t'(command) == CMD_START_AUTO) begin
                  auto_mode      <= 1'b1;
                  interval_count <= '0;
                  speed_goal     <= clamp_target({1'b0, rpm_value});
                end else begin
                  auto_mode <= 1'b0;
                end
                enable_level  <= 1'b0;
                speed_now     <= floor_x;
                applied_speed <= floor_rpm;
                applied_valid <= 1'b1;
                run_mode      <= 1'b1;
                retune_flag   <= 1'b1;
              end
              CMD_STOP: begin
                if (run_mode) begin
                  period_now    <= '0;
                  enable_level  <= 1'b1;
                  run_mode      <= 1'b0;
                  speed_now     <= '0;
                  applied_valid <= 1'b0;
                  auto_mode     <= 1'b0;
                end
              end
              CMD_SET_TARGET: speed_goal <= clamp_target({1'b0, rpm_value});
              default: ;
            endcase
          end
        end
        ST_DELTA: begin
          if (div_last) begin
            delta       <= hp_quo;
            delta_dirty <= 1'b0;
          end
        end
        // Measure the distance to the target
        ST_RAMP: begin
          dir_up <= speed_now < goal_x;
          gap    <= (speed_now < goal_x) ? (goal_x - speed_now) : (speed_now - goal_x);
        end
        ST_STEP: begin
          if (gap <= SPEED_W'(delta)) begin
            speed_now <= goal_x;
          end else if (dir_up) begin
            speed_now <= speed_now + SPEED_W'(delta);
          end else begin
            speed_now <= speed_now - SPEED_W'(delta);
          end
        end
        // Hold the deceleration floor
        ST_FLOOR: begin
          if (!dir_up && speed_now < floor_x && speed_goal >= floor_rpm) begin
            speed_now <= floor_x;
          end
        end
        ST_CHECK: begin
          if (retune_hit) begin
            applied_speed <= cur;
            applied_valid <= 1'b1;
            retune_flag   <= 1'b1;
          end
        end
        ST_MULT: begin
          if (applied_speed < R_FLOOR) begin
            period_now <= PERIOD_MAX;
          end
        end
        ST_DIV: begin
          if (div_last) begin
            period_now <= (hp_quo < QUO_W'(PERIOD_MIN)) ? PERIOD_MIN : hp_quo[PERIOD_W-1:0];
          end
        end
        // Count the auto ramp interval, then raise the auto ramp target or end the run
        ST_AUTO: begin
          if (auto_mode) begin
            if (cnt_inc >= auto_ramp_interval) begin
              interval_count <= '0;
              if (speed_goal < auto_ramp_limit) begin
                speed_goal <= clamp_target(goal_sum);
              end else begin
                period_now    <= '0;
                enable_level  <= 1'b1;
                run_mode      <= 1'b0;
                speed_now     <= '0;
                applied_valid <= 1'b0;
                auto_mode     <= 1'b0;
                retune_flag   <= 1'b0;
              end
            end else begin
              interval_count <= cnt_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Present the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      running         <= run_mode;
      auto_active     <= auto_mode;
      current_speed   <= cur;
      target_speed    <= speed_goal;
      retune          <= retune_flag;
      half_period_us  <= period_now;
      driver_enable_n <= enable_level;
    end
  end

endmodule

// File: rtl/core/ssrc_checker.sv
module ssrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          running,
  input logic                          auto_active,
  input logic [ssrc_pkg::RPM_W-1:0]    current_speed,
  input logic [ssrc_pkg::RPM_W-1:0]    target_speed,
  input logic                          retune,
  input logic [ssrc_pkg::PERIOD_W-1:0] half_period_us,
  input logic                          driver_enable_n
);
  import ssrc_pkg::*;

  // Driver enable tracks the run flag
  a_enable_follows_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (driver_enable_n == !running))
    else $error("driver enable disagrees with run state");

  // A stopped motor has no speed, no period, no auto mode and no retune
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !running) |-> (half_period_us == '0 && current_speed == '0 &&
                                 !auto_active && !retune))
    else $error("idle result carries running state");

  // A running motor has a half period within bounds
  a_period_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && running) |-> (half_period_us >= PERIOD_MIN && half_period_us <= PERIOD_MAX))
    else $error("half period out of range");

  // Target stays inside its clamp window
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (target_speed >= TARGET_MIN && target_speed <= TARGET_MAX))
    else $error("target speed out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(current_speed) &&
                                   $stable(half_period_us)))
    else $error("stalled result changed");

endmodule

bind stepper_speed_ramp_controller ssrc_checker u_ssrc_checker (.*);

// File: sim/speed_ramp_checker.sv
module speed_ramp_checker
  import ssrc_pkg::*;
#(
  parameter int MOTOR_STEPS = 1600
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [RPM_W-1:0]      rpm_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  running,
  input  logic                  auto_active,
  input  logic [RPM_W-1:0]      current_speed,
  input  logic [RPM_W-1:0]      target_speed,
  input  logic                  retune,
  input  logic [PERIOD_W-1:0]   half_period_us,
  input  logic                  driver_enable_n,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           errors,
  output int unsigned           pending,
  output int unsigned           results_seen,
  output int unsigned           retunes_seen
);

  // Acceleration in steps/s^2 to 1/65536 rpm per millisecond
  localparam longint unsigned STEP_SCALE = 64'd60 * 64'd65536;
  localparam longint unsigned MS_PER_S   = 64'd1000;
  localparam longint unsigned RPM_MASK   = 64'h1FFFF;

  typedef struct packed {
    logic                running;
    logic                auto_on;
    logic [RPM_W-1:0]    speed;
    logic [RPM_W-1:0]    target;
    logic                retune;
    logic [PERIOD_W-1:0] half_period;
    logic                drv_off;
  } motor_status_t;

  // Register copies
  logic [ACCEL_W-1:0]    cfg_accel;
  logic [RPM_W-1:0]      cfg_min_ramp;
  logic [RPM_W-1:0]      cfg_limit;
  logic [RPM_W-1:0]      cfg_incr;
  logic [INTERVAL_W-1:0] cfg_interval;

  // Predicted motor state
  bit                    run_on;
  bit                    auto_on;
  bit                    applied_ok;
  logic [SPEED_W-1:0]    speed_q16;
  logic [RPM_W-1:0]      goal_rpm;
  logic [RPM_W-1:0]      applied_rpm;
  logic [PERIOD_W-1:0]   period;
  logic [INTERVAL_W-1:0] ms_count;
  bit                    drv_off;

  motor_status_t status_due[$];

  function automatic logic [RPM_W-1:0] limit_target(input logic [RPM_W:0] v);
    if (v < {1'b0, TARGET_MIN}) return TARGET_MIN;
    if (v > {1'b0, TARGET_MAX}) return TARGET_MAX;
    return v[RPM_W-1:0];
  endfunction

  // Half period in us for a speed in 1/256 rpm, clamped to the legal window
  function automatic logic [PERIOD_W-1:0] period_for(input logic [RPM_W-1:0] r256);
    longint unsigned steps, num, h;
    steps = longint'(r256) * longint'(MOTOR_STEPS);
    num = HP_DIVIDEND;
    if (steps == 0) return PERIOD_MAX;
    h = num / steps;
    if (h > PERIOD_MAX) h = PERIOD_MAX;
    if (h < PERIOD_MIN) h = PERIOD_MIN;
    return h[PERIOD_W-1:0];
  endfunction

  function automatic void latch_period();
    applied_rpm = speed_q16[RPM_W+7:8];
    applied_ok = 1'b1;
    period = period_for(applied_rpm);
  endfunction

  function automatic void start_motor();
    drv_off = 1'b0;
    speed_q16 = SPEED_W'(longint'(cfg_min_ramp) << 8);
    latch_period();
    run_on = 1'b1;
  endfunction

  function automatic void halt_motor();
    if (!run_on) return;
    period = '0;
    drv_off = 1'b1;
    run_on = 1'b0;
    speed_q16 = '0;
    applied_ok = 1'b0;
    auto_on = 1'b0;
  endfunction

  // One millisecond of ramping; returns 1 when a new half period is applied
  function automatic bit ramp_step();
    longint unsigned goal_q, floor_q, step, now, cur, diff;
    goal_q = longint'(goal_rpm) << 8;
    floor_q = longint'(cfg_min_ramp) << 8;
    step = (longint'(cfg_accel) * STEP_SCALE) / (longint'(MOTOR_STEPS) * MS_PER_S);
    now = speed_q16;
    if (now < goal_q) begin
      now = (goal_q - now <= step) ? goal_q : now + step;
    end else if (now > goal_q) begin
      now = (now - goal_q <= step) ? goal_q : now - step;
      if (now < floor_q && goal_rpm >= cfg_min_ramp) now = floor_q;
    end else begin
      return 1'b0;
    end
    speed_q16 = now[SPEED_W-1:0];
    cur = (now >> 8) & RPM_MASK;
    diff = (cur > applied_rpm) ? cur - applied_rpm : applied_rpm - cur;
    if (!applied_ok || diff >= RETUNE_DELTA) begin
      latch_period();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command and return the status it leaves behind
  function automatic motor_status_t advance_motor(input logic [CMD_W-1:0] code,
                                                  input logic [RPM_W-1:0] rpm);
    motor_status_t s;
    bit moved, halted;
    moved = 1'b0;
    halted = 1'b0;
    case (code)
      CMD_TICK: begin
        if (run_on) begin
          moved = ramp_step();
          if (auto_on) begin
            if (ms_count != '1) ms_count++;
            if (ms_count >= cfg_interval) begin
              ms_count = '0;
              if (goal_rpm < cfg_limit) begin
                goal_rpm = limit_target({1'b0, goal_rpm} + {1'b0, cfg_incr});
              end else begin
                halt_motor();
                halted = 1'b1;
              end
            end
          end
        end
      end
      CMD_START_CONT: begin
        auto_on = 1'b0;
        start_motor();
        moved = 1'b1;
      end
      CMD_START_AUTO: begin
        auto_on = 1'b1;
        ms_count = '0;
        goal_rpm = limit_target({1'b0, rpm});
        start_motor();
        moved = 1'b1;
      end
      CMD_STOP: begin
        halt_motor();
        halted = 1'b1;
      end
      CMD_SET_TARGET: goal_rpm = limit_target({1'b0, rpm});
      default: ;
    endcase
    s.running = run_on;
    s.auto_on = auto_on;
    s.speed = speed_q16[RPM_W+7:8];
    s.target = goal_rpm;
    s.retune = moved && !halted;
    s.half_period = period;
    s.drv_off = drv_off;
    return s;
  endfunction

  always @(posedge clk) begin : watch
    motor_status_t got, want;
    if (rst) begin
      cfg_accel = ACCEL_RST;
      cfg_min_ramp = MIN_RAMP_RST;
      cfg_limit = LIMIT_RST;
      cfg_incr = INCR_RST;
      cfg_interval = INTERVAL_RST;
      run_on = 1'b0;
      auto_on = 1'b0;
      applied_ok = 1'b0;
      speed_q16 = '0;
      goal_rpm = GOAL_RST;
      applied_rpm = '0;
      period = '0;
      ms_count = '0;
      drv_off = 1'b1;
      status_due.delete();
      errors = 0;
      pending = 0;
      results_seen = 0;
      retunes_seen = 0;
    end else begin
      // Compare the result transaction with the oldest expectation
      if (out_valid && out_ready) begin
        got = '{running, auto_active, current_speed, target_speed, retune,
                half_period_us, driver_enable_n};
        results_seen++;
        if (retune === 1'b1) retunes_seen++;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result: run=%0d auto=%0d speed=%0d target=%0d",
                     $realtime, running, auto_active, current_speed, target_speed);
        end else begin
          want = status_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch (run auto speed target retune half drv_n)", $realtime);
              $display("  want %0d %0d %0d %0d %0d %0d %0d",
                       want.running, want.auto_on, want.speed, want.target,
                       want.retune, want.half_period, want.drv_off);
              $display("  got  %0d %0d %0d %0d %0d %0d %0d",
                       got.running, got.auto_on, got.speed, got.target,
                       got.retune, got.half_period, got.drv_off);
            end
          end
        end
      end

      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_ACCEL:    cfg_accel = cfg_data[ACCEL_W-1:0];
          REG_MIN_RAMP: cfg_min_ramp = cfg_data[RPM_W-1:0];
          REG_LIMIT:    cfg_limit = cfg_data[RPM_W-1:0];
          REG_INCR:     cfg_incr = cfg_data[RPM_W-1:0];
          REG_INTERVAL: cfg_interval = cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end

      // Predict the status for each accepted command transaction
      if (in_valid && in_ready) status_due.push_back(advance_motor(command, rpm_value));
      pending = status_due.size();
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import ssrc_pkg::*;

  localparam int STEPS = 1600;
  localparam int RPM_FULL = (1 << RPM_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = CMD_TICK;
  logic [RPM_W-1:0]      rpm_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  running;
  logic                  auto_active;
  logic [RPM_W-1:0]      current_speed;
  logic [RPM_W-1:0]      target_speed;
  logic                  retune;
  logic [PERIOD_W-1:0]   half_period_us;
  logic                  driver_enable_n;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACCEL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned errors, pending, results_seen, retunes_seen;
  int unsigned n_items = 0, n_auto = 0, n_stops = 0, n_writes = 0, n_phases = 0;
  int          burst_left = 0;
  int          ready_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stepper_speed_ramp_controller #(.STEPS_PER_REVOLUTION(STEPS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .rpm_value(rpm_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .running(running), .auto_active(auto_active), .current_speed(current_speed),
    .target_speed(target_speed), .retune(retune), .half_period_us(half_period_us),
    .driver_enable_n(driver_enable_n),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  speed_ramp_checker #(.MOTOR_STEPS(STEPS)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .rpm_value(rpm_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .running(running), .auto_active(auto_active), .current_speed(current_speed),
    .target_speed(target_speed), .retune(retune), .half_period_us(half_period_us),
    .driver_enable_n(driver_enable_n),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .retunes_seen(retunes_seen)
  );

  // Result side: stall pattern with short stalls and long open stretches
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready <= 1'b1;
          ready_left = $urandom_range(100, 300);
        end
        1, 2, 3: begin
          out_ready <= 1'b0;
          ready_left = $urandom_range(0, 7);
        end
        default: begin
          out_ready <= 1'b1;
          ready_left = $urandom_range(0, 15);
        end
      endcase
    end
  end

  // Send one command transaction; bursts of random length with random gaps
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [RPM_W-1:0] rpm);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= code;
    rpm_value <= rpm;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (code == CMD_START_AUTO) n_auto++;
    if (code == CMD_STOP) n_stops++;
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    n_writes++;
  endtask

  task automatic write_settings(input int unsigned accel, input int unsigned min_ramp,
                                input int unsigned limit, input int unsigned incr,
                                input int unsigned interval);
    drain_results();
    write_reg(REG_ACCEL, accel);
    write_reg(REG_MIN_RAMP, min_ramp);
    write_reg(REG_LIMIT, limit);
    write_reg(REG_INCR, incr);
    write_reg(REG_INTERVAL, interval);
    cfg_write <= 1'b0;
    n_phases++;
  endtask

  // Random subset of registers, biased toward fast ramps and short intervals
  task automatic write_random_settings();
    drain_results();
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_ACCEL, ($urandom_range(0, 3) == 0) ? $urandom_range(100, 20000)
                                                        : $urandom_range(8000, 20000));
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_MIN_RAMP, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 102400)
                                                          : $urandom_range(6000, 16000));
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_LIMIT, $urandom_range(TARGET_MIN, TARGET_MAX));
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_INCR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 102400)
                                                      : $urandom_range(0, 20000));
    if ($urandom_range(0, 9) < 6)
      write_reg(REG_INTERVAL, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                          : $urandom_range(1, 40));
    cfg_write <= 1'b0;
    n_phases++;
  endtask

  // Speeds mostly near the low end of the window so the ramp can reach them
  function automatic logic [RPM_W-1:0] pick_rpm();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    return RPM_W'($urandom_range(0, RPM_FULL));
      2:       return RPM_W'($urandom_range(0, TARGET_MIN));
      3:       return RPM_W'($urandom_range(90000, RPM_FULL));
      4:       return ($urandom_range(0, 1) != 0) ? RPM_W'(RPM_FULL) : RPM_W'(0);
      default: return RPM_W'($urandom_range(TARGET_MIN, TARGET_MIN + 6000));
    endcase
  endfunction

  // Typically a start, a run of ticks with target changes, and some noise
  task automatic run_phase(input int n_cmds);
    int unsigned pick;
    logic [CMD_W-1:0] odd_code;
    if ($urandom_range(0, 9) < 7)
      send_command(($urandom_range(0, 1) != 0) ? CMD_START_AUTO : CMD_START_CONT, pick_rpm());
    for (int k = 0; k < n_cmds; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_command(CMD_TICK, RPM_W'($urandom_range(0, RPM_FULL)));
      end else if (pick < 82) begin
        send_command(CMD_SET_TARGET, pick_rpm());
      end else if (pick < 87) begin
        send_command(CMD_START_CONT, pick_rpm());
      end else if (pick < 92) begin
        send_command(CMD_START_AUTO, pick_rpm());
      end else if (pick < 96) begin
        send_command(CMD_STOP, pick_rpm());
      end else begin
        odd_code = CMD_SET_TARGET + CMD_W'($urandom_range(1, 3));
        send_command(odd_code, RPM_W'($urandom_range(0, RPM_FULL)));
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  task automatic run_directed();
    // Idle behavior, unused codes and target clamping
    send_command(CMD_TICK, '0);
    send_command(CMD_STOP, RPM_W'(RPM_FULL));
    send_command(CMD_SET_TARGET + CMD_W'(1), RPM_W'(RPM_FULL));
    send_command(CMD_SET_TARGET + CMD_W'(3), '0);
    send_command(CMD_SET_TARGET, '0);
    send_command(CMD_SET_TARGET, RPM_W'(RPM_FULL));
    send_command(CMD_SET_TARGET, TARGET_MAX);
    // Continuous run, target drop, restart while running
    send_command(CMD_START_CONT, '0);
    repeat (3) send_command(CMD_TICK, '0);
    send_command(CMD_SET_TARGET, TARGET_MIN);
    send_command(CMD_TICK, '0);
    send_command(CMD_START_CONT, '0);
    // Auto starts at both clamp edges, stop while running and while idle
    send_command(CMD_START_AUTO, RPM_W'(RPM_FULL));
    send_command(CMD_TICK, '0);
    send_command(CMD_START_AUTO, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_STOP, '0);
    send_command(CMD_STOP, '0);
    send_command(CMD_TICK, '0);
    // Zero floor speed gives the longest half period; auto ramp at its limit stops on a tick
    write_settings(ACCEL_RST, 0, TARGET_MIN, INCR_RST, 1);
    send_command(CMD_START_CONT, '0);
    send_command(CMD_TICK, '0);
    send_command(CMD_START_AUTO, TARGET_MIN);
    send_command(CMD_TICK, '0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // Register extremes first, then random settings
    write_settings(100, 0, TARGET_MIN, 0, 65535);
    run_phase(40);
    write_settings(20000, 102400, TARGET_MAX, 102400, 1);
    run_phase(40);
    while (n_items < 525) begin
      write_random_settings();
      run_phase($urandom_range(25, 70));
    end
    drain_results();
    repeat (120) @(negedge clk);
    $display("Ran %0d commands (%0d auto starts, %0d stops) over %0d register settings",
             n_items, n_auto, n_stops, n_phases);
    $display("Checked %0d results, %0d with a new half period, after %0d register writes",
             results_seen, retunes_seen, n_writes);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/core/ssrc_pkg.sv
rtl/core/stepper_speed_ramp_controller.sv
rtl/core/ssrc_checker.sv
sim/speed_ramp_checker.sv
sim/testbench.sv
